### src/assert_macros.svh
// Assertion macros used by the RTL of the ALU and shifter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/alusf_pkg.sv
// Package with the types and codes of the ALU and shifter with status flags.
`timescale 1ns / 1ps
package alusf_pkg;

  // Opcode groups.
  localparam logic [1:0] OPC_ALU   = 2'd0;
  localparam logic [1:0] OPC_SHIFT = 2'd1;
  localparam logic [1:0] OPC_LOAD  = 2'd2;
  localparam logic [1:0] OPC_NONE  = 2'd3;

  // Arithmetic and logic operations.
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_OR  = 3'd1;
  localparam logic [2:0] ALU_ADC = 3'd2;
  localparam logic [2:0] ALU_SBB = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_SUB = 3'd5;
  localparam logic [2:0] ALU_XOR = 3'd6;
  localparam logic [2:0] ALU_CMP = 3'd7;

  // Shift and rotate operations.
  localparam logic [2:0] SH_ROL  = 3'd0;
  localparam logic [2:0] SH_ROR  = 3'd1;
  localparam logic [2:0] SH_RCL  = 3'd2;
  localparam logic [2:0] SH_RCR  = 3'd3;
  localparam logic [2:0] SH_SHL  = 3'd4;
  localparam logic [2:0] SH_SHR  = 3'd5;
  localparam logic [2:0] SH_SHL2 = 3'd6;
  localparam logic [2:0] SH_SAR  = 3'd7;

  localparam logic [15:0] MASK_WORD = 16'hFFFF;
  localparam logic [15:0] MASK_BYTE = 16'h00FF;

  // Bit positions in the flag word taken by a flag load.
  localparam int unsigned LD_CF = 0;
  localparam int unsigned LD_PF = 2;
  localparam int unsigned LD_AF = 4;
  localparam int unsigned LD_ZF = 6;
  localparam int unsigned LD_SF = 7;
  localparam int unsigned LD_OF = 11;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  op_select;
    logic        word_size;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic        carry_out;
    logic        aux_out;
    logic        overflow_out;
    logic        parity_out;
    logic        zero_out;
    logic        sign_out;
  } out_item_t;

  typedef struct packed {
    logic sf;
    logic zf;
    logic pf;
    logic of;
    logic af;
    logic cf;
  } flags_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_FIN   = 3'b100
  } state_t;

endpackage

### src/alu_shifter_with_flags.sv
// Top level of the 8/16-bit ALU and shifter that keeps six status flags.
//
//   channel | direction | ports                          | payload
//   in      | input     | in_valid, in_stall, in_data    | opcode, operands, width
//   out     | output     | out_valid, out_stall, out_data | result and the six flags
//
// An ALU operation, a flag load or a shift with a zero count goes from ST_IDLE
// straight to ST_FIN; a shift by n first stays in ST_SHIFT until n runs down to
// zero, since the shared one-bit shift step moves the operand by one place a cycle.
// Reset clears the flags, the sequencer and the output valid.
// A stalled output holds the finished transaction; the next input is still taken
// meanwhile, and only the ST_FIN step of that one waits for the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module alu_shifter_with_flags (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  alusf_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output alusf_pkg::out_item_t out_data
);
  import alusf_pkg::*;

  state_t      state_r, state_nxt;
  flags_t      flags_r, flags_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  // Working registers of the current transaction.
  logic [1:0]  opc_r;
  logic [2:0]  sel_r;
  logic        word_r;
  logic [15:0] a_r, a_nxt;
  logic [15:0] b_r;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        c_r, c_nxt;
  logic        orig_top_r;
  logic        sh_act_r;

  logic        in_fire;
  logic        out_free;
  logic        fin_fire;
  logic [15:0] in_mask;
  logic [3:0]  in_cnt;
  logic        in_top;

  logic [15:0] mask;
  logic        a_top, a_next;
  logic [16:0] sum;
  logic [15:0] res;
  logic        r_top;
  logic        fill;
  logic [15:0] step_a;
  logic        step_c;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign fin_fire = (state_r == ST_FIN) && out_free;

  assign in_mask = in_data.word_size ? MASK_WORD : MASK_BYTE;
  assign in_cnt  = in_data.word_size ? in_data.second_operand[3:0]
                                     : {1'b0, in_data.second_operand[2:0]};
  assign in_top  = in_data.word_size ? in_data.first_operand[15] : in_data.first_operand[7];

  assign mask   = word_r ? MASK_WORD : MASK_BYTE;
  assign a_top  = word_r ? a_r[15] : a_r[7];
  assign a_next = word_r ? a_r[14] : a_r[6];

  // Shared shift unit: moves the operand by one place.
  always_comb begin
    step_a = a_r;
    step_c = c_r;
    fill   = 1'b0;
    if (!sel_r[0]) begin
      step_c = a_top;
      unique case (sel_r)
        SH_ROL:  fill = a_top;
        SH_RCL:  fill = c_r;
        default: fill = 1'b0;
      endcase
      step_a = {a_r[14:0], fill} & mask;
    end else begin
      step_c = a_r[0];
      unique case (sel_r)
        SH_ROR:  fill = a_r[0];
        SH_RCR:  fill = c_r;
        SH_SAR:  fill = a_top;
        default: fill = 1'b0;
      endcase
      step_a = {1'b0, a_r[15:1]};
      if (word_r) begin
        step_a[15] = fill;
      end else begin
        step_a[7] = fill;
      end
    end
  end

  // Final result and flags of the transaction.
  always_comb begin
    flags_nxt = flags_r;
    sum       = '0;
    res       = '0;
    unique case (opc_r)
      OPC_ALU: begin
        unique case (sel_r)
          ALU_ADD, ALU_ADC: begin
            sum = {1'b0, a_r} + {1'b0, b_r}
                + {16'd0, (sel_r == ALU_ADC) ? flags_r.cf : 1'b0};
          end
          ALU_SUB, ALU_SBB, ALU_CMP: begin
            sum = {1'b0, a_r} - {1'b0, b_r}
                - {16'd0, (sel_r == ALU_SBB) ? flags_r.cf : 1'b0};
          end
          ALU_OR:  sum = {1'b0, a_r | b_r};
          ALU_AND: sum = {1'b0, a_r & b_r};
          default: sum = {1'b0, a_r ^ b_r};
        endcase
        res = sum[15:0] & mask;
      end
      OPC_SHIFT: res = a_r;
      default:   res = '0;
    endcase
    r_top = word_r ? res[15] : res[7];

    unique case (opc_r)
      OPC_ALU: begin
        unique case (sel_r)
          ALU_ADD, ALU_ADC: begin
            flags_nxt.cf = word_r ? sum[16] : sum[8];
            flags_nxt.af = a_r[4] ^ b_r[4] ^ sum[4];
            flags_nxt.of = (a_top == (word_r ? b_r[15] : b_r[7])) && (r_top != a_top);
          end
          ALU_SUB, ALU_SBB, ALU_CMP: begin
            flags_nxt.cf = word_r ? sum[16] : sum[8];
            flags_nxt.af = a_r[4] ^ b_r[4] ^ sum[4];
            flags_nxt.of = (a_top != (word_r ? b_r[15] : b_r[7])) && (r_top != a_top);
          end
          default: begin
            flags_nxt.cf = 1'b0;
            flags_nxt.af = sum[4];
            flags_nxt.of = 1'b0;
          end
        endcase
        flags_nxt.pf = ~^res[7:0];
        flags_nxt.zf = (res == '0);
        flags_nxt.sf = r_top;
      end
      OPC_SHIFT: begin
        // A zero count leaves every flag as it was.
        if (sh_act_r) begin
          flags_nxt.cf = c_r;
          unique case (sel_r)
            SH_ROL, SH_RCL: flags_nxt.of = a_top ^ c_r;
            SH_ROR, SH_RCR: flags_nxt.of = a_top ^ a_next;
            SH_SHL, SH_SHL2: flags_nxt.of = a_top ^ c_r;
            SH_SHR: flags_nxt.of = orig_top_r;
            default: flags_nxt.of = 1'b0;
          endcase
          if (sel_r[2]) begin
            flags_nxt.pf = ~^a_r[7:0];
            flags_nxt.zf = (a_r == '0);
            flags_nxt.sf = a_top;
          end
        end
      end
      OPC_LOAD: begin
        flags_nxt.cf = a_r[LD_CF];
        flags_nxt.pf = a_r[LD_PF];
        flags_nxt.af = a_r[LD_AF];
        flags_nxt.zf = a_r[LD_ZF];
        flags_nxt.sf = a_r[LD_SF];
        flags_nxt.of = a_r[LD_OF];
      end
      default: flags_nxt = flags_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    c_nxt     = c_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_data.opcode == OPC_SHIFT) && (in_cnt != '0)) begin
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SHIFT: begin
        a_nxt   = step_a;
        c_nxt   = step_c;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (fin_fire) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.result       = res;
      out_data_nxt.carry_out    = flags_nxt.cf;
      out_data_nxt.aux_out      = flags_nxt.af;
      out_data_nxt.overflow_out = flags_nxt.of;
      out_data_nxt.parity_out   = flags_nxt.pf;
      out_data_nxt.zero_out     = flags_nxt.zf;
      out_data_nxt.sign_out     = flags_nxt.sf;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_fire) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      opc_r      <= in_data.opcode;
      sel_r      <= in_data.op_select;
      word_r     <= in_data.word_size;
      // A flag load needs the whole flag word, so it is taken unmasked.
      a_r        <= (in_data.opcode == OPC_LOAD) ? in_data.first_operand
                                                 : (in_data.first_operand & in_mask);
      b_r        <= in_data.second_operand & in_mask;
      cnt_r      <= in_cnt;
      c_r        <= flags_r.cf;
      orig_top_r <= in_top;
      sh_act_r   <= (in_cnt != '0);
    end else begin
      a_r   <= a_nxt;
      c_r   <= c_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_accept_starts_work, in_fire |=> (state_r != ST_IDLE), "accepted transaction not started")
  `ASSERT_CLK(a_flags_only_at_finish, !fin_fire |=> $stable(flags_r), "flags changed outside finish")
  `ASSERT_CLK(a_shift_count_live, (state_r == ST_SHIFT) |-> (cnt_r != 4'd0), "shift with zero count")
  `ASSERT_CLK(a_finish_loads_output, fin_fire |=> out_valid_r, "finished result not presented")

endmodule
